// ===== sv/irpd_pkg.sv =====
// Shared types and constants for the IR pulse-distance decoder.
package irpd_pkg;

   localparam int unsigned TIME_W = 16;
   localparam int unsigned LED_CODE_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_LEADER = 2'd1,
      KIND_ZERO   = 2'd2,
      KIND_ONE    = 2'd3
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LEADER_MIN    = 3'd0,
      CSR_LEADER_MAX    = 3'd1,
      CSR_ZERO_MIN      = 3'd2,
      CSR_ZERO_MAX      = 3'd3,
      CSR_ONE_MIN       = 3'd4,
      CSR_ONE_MAX       = 3'd5,
      CSR_LED_LOW_CODE  = 3'd6,
      CSR_LED_HIGH_CODE = 3'd7
   } csr_index_type;

   // Exclusive interval bounds for the three symbol classes.
   typedef struct packed {
      logic [TIME_W-1:0] leader_min;
      logic [TIME_W-1:0] leader_max;
      logic [TIME_W-1:0] zero_min;
      logic [TIME_W-1:0] zero_max;
      logic [TIME_W-1:0] one_min;
      logic [TIME_W-1:0] one_max;
   } windows_type;

   localparam logic [TIME_W-1:0] RST_LEADER_MIN = 16'd490;
   localparam logic [TIME_W-1:0] RST_LEADER_MAX = 16'd520;
   localparam logic [TIME_W-1:0] RST_ZERO_MIN   = 16'd100;
   localparam logic [TIME_W-1:0] RST_ZERO_MAX   = 16'd125;
   localparam logic [TIME_W-1:0] RST_ONE_MIN    = 16'd210;
   localparam logic [TIME_W-1:0] RST_ONE_MAX    = 16'd240;
   localparam logic [LED_CODE_W-1:0] RST_LED_LOW_CODE  = 32'h0687_CBF0;
   localparam logic [LED_CODE_W-1:0] RST_LED_HIGH_CODE = 32'h0687_CBC8;

endpackage

// ===== sv/irpd_classify.sv =====
// Interval computation and window classification of one capture.
module irpd_classify
   import irpd_pkg::*;
(
   input  logic [TIME_W-1:0] capture_time,
   input  logic [TIME_W-1:0] last_capture,
   input  windows_type       windows,
   output kind_type          kind
);

   logic [TIME_W-1:0] delta;
   logic              hit_leader;
   logic              hit_zero;
   logic              hit_one;

   // wraps modulo 2^16 like the free-running timer
   assign delta = capture_time - last_capture;

   assign hit_leader = (delta > windows.leader_min) && (delta < windows.leader_max);
   assign hit_zero   = (delta > windows.zero_min)   && (delta < windows.zero_max);
   assign hit_one    = (delta > windows.one_min)    && (delta < windows.one_max);

   // leader beats zero, zero beats one
   always_comb begin
      if (hit_leader) begin
         kind = KIND_LEADER;
      end else if (hit_zero) begin
         kind = KIND_ZERO;
      end else if (hit_one) begin
         kind = KIND_ONE;
      end else begin
         kind = KIND_NONE;
      end
   end

endmodule

// ===== sv/ir_pulse_distance_decoder.sv =====
// Top level of the IR pulse-distance (NEC style) remote decoder.
//
// Each req item carries a 16-bit timer value latched at a rising edge of the IR
// receiver. The block takes the interval from the previous capture (modulo 2^16,
// starting from zero after reset) and classifies it against three exclusive
// windows, checked in the order leader, zero bit, one bit. A leader clears the
// code shift register and bit count; a zero or one bit shifts in at the LSB
// until CODE_BITS bits are gathered. The item that brings the last bit returns
// rsp_tlast high, and the finished code is compared against led_low_code (wins
// on a tie) and led_high_code to set the LED level. Further bits are ignored
// until the next leader. Every req item yields exactly one rsp item, carrying
// the low 32 bits of the shift register and the LED level. Classification
// and state update are done in the accept cycle and land in the output
// register. One item per cycle is sustained; the output register refills in
// the same cycle it is drained, so req_tready only drops while a result waits
// and rsp_tready is low. The user must write registers through the csr_ port
// (package index order) only while the block is idle; this is not enforced.
module ir_pulse_distance_decoder
   import irpd_pkg::*;
#(
   parameter int unsigned CODE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] capture_time

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // [31:0] received_code, [32] led_level
   output logic                  rsp_tlast,   // code_done
   output logic [1:0]            rsp_tuser,   // [1:0] symbol_kind

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // bit count runs 0 .. CODE_BITS+1
   localparam int unsigned BITS_W = $clog2(CODE_BITS + 2);
   localparam int unsigned CMP_W  = (CODE_BITS > LED_CODE_W) ? CODE_BITS : LED_CODE_W;
   localparam logic [BITS_W-1:0] BITS_FULL = BITS_W'(CODE_BITS);

   // configuration
   windows_type             windows_ff;
   logic [LED_CODE_W-1:0]   led_low_code_ff;
   logic [LED_CODE_W-1:0]   led_high_code_ff;

   // decoder state
   logic [TIME_W-1:0]       last_capture_ff;
   logic [TIME_W-1:0]       last_capture_in;
   logic [CODE_BITS-1:0]    code_shift_ff;
   logic [CODE_BITS-1:0]    code_shift_in;
   logic [BITS_W-1:0]       bits_seen_ff;
   logic [BITS_W-1:0]       bits_seen_in;
   logic                    led_state_ff;
   logic                    led_state_in;

   // output register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   kind_type                rsp_kind_ff;
   logic                    rsp_done_ff;
   logic                    done_in;
   logic [LED_CODE_W-1:0]   rsp_code_ff;
   logic [LED_CODE_W-1:0]   rsp_code_in;
   logic                    rsp_led_ff;

   kind_type                kind;
   logic                    req_accept;
   logic [CMP_W-1:0]        shift_ext;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   irpd_classify u_classify (
      .capture_time (req_tdata[TIME_W-1:0]),
      .last_capture (last_capture_ff),
      .windows      (windows_ff),
      .kind         (kind)
   );

   // next state for the item at the port
   always_comb begin
      last_capture_in = req_tdata[TIME_W-1:0];
      code_shift_in   = code_shift_ff;
      bits_seen_in    = bits_seen_ff;
      led_state_in    = led_state_ff;
      done_in         = 1'b0;

      if (kind == KIND_LEADER) begin
         code_shift_in = '0;
         bits_seen_in  = '0;
      end

      if ((kind == KIND_ZERO || kind == KIND_ONE) && bits_seen_in < BITS_FULL) begin
         code_shift_in = {code_shift_in[CODE_BITS-2:0], kind == KIND_ONE};
         bits_seen_in  = bits_seen_in + 1'b1;
      end

      shift_ext = CMP_W'(code_shift_in);

      if (bits_seen_in == BITS_FULL) begin
         done_in = 1'b1;
         // full-width compare: stray high bits prevent a match
         if (shift_ext == CMP_W'(led_low_code_ff)) begin
            led_state_in = 1'b0;
         end else if (shift_ext == CMP_W'(led_high_code_ff)) begin
            led_state_in = 1'b1;
         end
         bits_seen_in = bits_seen_in + 1'b1;
      end

      rsp_code_in = shift_ext[LED_CODE_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         windows_ff.leader_min <= RST_LEADER_MIN;
         windows_ff.leader_max <= RST_LEADER_MAX;
         windows_ff.zero_min   <= RST_ZERO_MIN;
         windows_ff.zero_max   <= RST_ZERO_MAX;
         windows_ff.one_min    <= RST_ONE_MIN;
         windows_ff.one_max    <= RST_ONE_MAX;
         led_low_code_ff       <= RST_LED_LOW_CODE;
         led_high_code_ff      <= RST_LED_HIGH_CODE;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_LEADER_MIN:    windows_ff.leader_min <= csr_wdata[TIME_W-1:0];
            CSR_LEADER_MAX:    windows_ff.leader_max <= csr_wdata[TIME_W-1:0];
            CSR_ZERO_MIN:      windows_ff.zero_min   <= csr_wdata[TIME_W-1:0];
            CSR_ZERO_MAX:      windows_ff.zero_max   <= csr_wdata[TIME_W-1:0];
            CSR_ONE_MIN:       windows_ff.one_min    <= csr_wdata[TIME_W-1:0];
            CSR_ONE_MAX:       windows_ff.one_max    <= csr_wdata[TIME_W-1:0];
            CSR_LED_LOW_CODE:  led_low_code_ff       <= csr_wdata[LED_CODE_W-1:0];
            CSR_LED_HIGH_CODE: led_high_code_ff      <= csr_wdata[LED_CODE_W-1:0];
            default: ;
         endcase
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_capture_ff <= '0;
         code_shift_ff   <= '0;
         bits_seen_ff    <= '0;
         led_state_ff    <= 1'b1;
      end else if (req_accept) begin
         last_capture_ff <= last_capture_in;
         code_shift_ff   <= code_shift_in;
         bits_seen_ff    <= bits_seen_in;
         led_state_ff    <= led_state_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_kind_ff <= kind;
         rsp_done_ff <= done_in;
         rsp_code_ff <= rsp_code_in;
         rsp_led_ff  <= led_state_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_led_ff, rsp_code_ff};
   assign rsp_tlast  = rsp_done_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

// ===== test/tb_ir_pulse_distance_decoder.sv =====
// Self-checking testbench for the IR pulse-distance remote decoder.
module tb_ir_pulse_distance_decoder;
   import irpd_pkg::*;

   localparam int CODE_BITS = 32;
   // Cycles with no item moving on either channel before the run is abandoned.
   // The longest planned stall is the receiver hold-off below (HOLD_CYCLES).
   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 500;
   localparam int ITEMS_PER_PHASE = 275;
   localparam int NUM_PHASES = 7;

   // Interval boundaries around the reset windows: inside and just outside.
   localparam logic [15:0] BOUNDARY_GAPS [12] = '{
      16'd101, 16'd100, 16'd125, 16'd124, 16'd211, 16'd210,
      16'd240, 16'd239, 16'd491, 16'd490, 16'd520, 16'd519
   };

   // One decoded result, field by field.
   typedef struct {
      kind_type    kind;
      logic        done;
      logic [31:0] code;
      logic        led;
   } decode_result_type;

   // Predicts the decoder output for each accepted capture and checks results
   // in order against it.
   class ir_decode_scoreboard;
      windows_type       win;
      logic [31:0]       low_code;
      logic [31:0]       high_code;
      logic [15:0]       prev_capture;
      logic [31:0]       shift_reg;
      int unsigned       bit_count;
      logic              led;
      decode_result_type pending_results[$];
      int unsigned       captures_taken;
      int unsigned       mismatches;

      function new();
         win = '{RST_LEADER_MIN, RST_LEADER_MAX, RST_ZERO_MIN, RST_ZERO_MAX,
                 RST_ONE_MIN, RST_ONE_MAX};
         low_code = RST_LED_LOW_CODE;
         high_code = RST_LED_HIGH_CODE;
         prev_capture = '0;
         shift_reg = '0;
         bit_count = 0;
         led = 1'b1;
         captures_taken = 0;
         mismatches = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_LEADER_MIN:    win.leader_min = value[15:0];
            CSR_LEADER_MAX:    win.leader_max = value[15:0];
            CSR_ZERO_MIN:      win.zero_min = value[15:0];
            CSR_ZERO_MAX:      win.zero_max = value[15:0];
            CSR_ONE_MIN:       win.one_min = value[15:0];
            CSR_ONE_MAX:       win.one_max = value[15:0];
            CSR_LED_LOW_CODE:  low_code = value;
            CSR_LED_HIGH_CODE: high_code = value;
            default: ;
         endcase
      endfunction

      function bit in_band(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
         return v > lo && v < hi;
      endfunction

      function void note_capture(logic [15:0] capture);
         logic [15:0]       delta;
         decode_result_type r;
         delta = capture - prev_capture;
         prev_capture = capture;
         captures_taken++;
         r.kind = KIND_NONE;
         r.done = 1'b0;
         if (in_band(delta, win.leader_min, win.leader_max)) begin
            r.kind = KIND_LEADER;
            shift_reg = '0;
            bit_count = 0;
         end else if (in_band(delta, win.zero_min, win.zero_max)) begin
            r.kind = KIND_ZERO;
         end else if (in_band(delta, win.one_min, win.one_max)) begin
            r.kind = KIND_ONE;
         end
         if ((r.kind == KIND_ZERO || r.kind == KIND_ONE) && bit_count < CODE_BITS) begin
            shift_reg = {shift_reg[CODE_BITS-2:0], r.kind == KIND_ONE};
            bit_count++;
         end
         // Code complete: low code wins over high code, no match keeps the level.
         if (bit_count == CODE_BITS) begin
            r.done = 1'b1;
            if (shift_reg == low_code)
               led = 1'b0;
            else if (shift_reg == high_code)
               led = 1'b1;
            bit_count++;
         end
         r.code = shift_reg;
         r.led = led;
         pending_results.push_back(r);
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         mismatches++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      endfunction

      function void check_result(decode_result_type got);
         decode_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result: expected none, %s %0d done %0d code %h led %0d",
                     $time, "actual kind", got.kind, got.done, got.code, got.led);
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind)
            report("symbol_kind", 32'(want.kind), 32'(got.kind));
         if (got.done !== want.done)
            report("code_done", 32'(want.done), 32'(got.done));
         if (got.code !== want.code)
            report("received_code", want.code, got.code);
         if (got.led !== want.led)
            report("led_level", 32'(want.led), 32'(got.led));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [39:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic [1:0]            rsp_tuser;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ir_decode_scoreboard board = new();

   logic [15:0] next_capture = '0;   // last capture time offered
   int          burst_left = 0;
   int          gap_max = 6;         // longest sender gap, per phase
   int          quiet_cycles = 0;
   bit          hold_done = 1'b0;

   ir_pulse_distance_decoder #(.CODE_BITS(CODE_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),     // [15:0] capture_time
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),     // [31:0] received_code, [32] led_level
      .rsp_tlast(rsp_tlast),     // code_done
      .rsp_tuser(rsp_tuser),     // [1:0] symbol_kind
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Monitor: sample both channels at the rising edge, before the block updates.
   // Also the watchdog: any item moving on either side counts as progress.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_result('{kind_type'(rsp_tuser), rsp_tlast, rsp_tdata[31:0],
                                 rsp_tdata[32]});
         if (req_tvalid && req_tready)
            board.note_capture(req_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Receiver: the stall pattern changes at random intervals between always
   // ready, coin flip, mostly stalled and mostly ready. Once, well into the
   // run, it holds off for a long stretch so the output register fills and
   // req_tready drops while the sender keeps offering.
   initial begin
      int mode;
      int span;
      rsp_tready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 80);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = 1'($urandom_range(0, 1));
               2: rsp_tready = ($urandom_range(0, 7) == 0);
               default: rsp_tready = ($urandom_range(0, 3) != 0);
            endcase
         end
         if (!hold_done && board.captures_taken >= 800) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
      end
   end

   // Offer one capture and wait for the handshake; returns at a falling edge.
   task automatic send_capture(logic [15:0] t);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, gap_max)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tdata = t;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      next_capture = t;
   endtask

   task automatic send_interval(logic [15:0] delta);
      send_capture(next_capture + delta);
   endtask

   // Random interval strictly inside (lo, hi); noise if the window is empty.
   function automatic logic [15:0] pick_in(logic [15:0] lo, logic [15:0] hi);
      if (int'(hi) > int'(lo) + 1)
         return 16'($urandom_range(int'(lo) + 1, int'(hi) - 1));
      return 16'($urandom_range(0, 65535));
   endfunction

   // Leader plus 32 bits MSB first, now and then broken, then a few stray bits.
   task automatic send_frame(logic [31:0] code);
      int extra;
      send_interval(pick_in(board.win.leader_min, board.win.leader_max));
      for (int i = 31; i >= 0; i--) begin
         if ($urandom_range(0, 39) == 0) begin
            if ($urandom_range(0, 1) == 0)
               return;                                       // truncated frame
            send_interval(16'($urandom_range(0, 65535)));    // glitch inside the frame
         end
         if (code[i])
            send_interval(pick_in(board.win.one_min, board.win.one_max));
         else
            send_interval(pick_in(board.win.zero_min, board.win.zero_max));
      end
      // Bits after a complete code are classified but must not shift in.
      extra = $urandom_range(0, 2);
      repeat (extra) begin
         if ($urandom_range(0, 1) == 0)
            send_interval(pick_in(board.win.one_min, board.win.one_max));
         else
            send_interval(pick_in(board.win.zero_min, board.win.zero_max));
      end
   endtask

   // Config writes happen only while idle, so the predictor follows at once.
   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      board.write_reg(idx, value);
   endtask

   task automatic write_windows(logic [15:0] l_lo, logic [15:0] l_hi, logic [15:0] z_lo,
                                logic [15:0] z_hi, logic [15:0] o_lo, logic [15:0] o_hi);
      write_reg(CSR_LEADER_MIN, 32'(l_lo));
      write_reg(CSR_LEADER_MAX, 32'(l_hi));
      write_reg(CSR_ZERO_MIN, 32'(z_lo));
      write_reg(CSR_ZERO_MAX, 32'(z_hi));
      write_reg(CSR_ONE_MIN, 32'(o_lo));
      write_reg(CSR_ONE_MAX, 32'(o_hi));
   endtask

   // Sender pauses until every expected result is back, so nothing is in flight.
   task automatic drain();
      req_tvalid = 1'b0;
      while (board.pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure_phase(int phase);
      logic [15:0] base;
      logic [31:0] shared;
      case (phase)
         1: begin
            // Realistic but moved windows, fresh LED codes.
            base = 16'($urandom_range(300, 500));
            write_reg(CSR_LEADER_MIN, 32'(base));
            write_reg(CSR_LEADER_MAX, base + $urandom_range(2, 60));
            base = 16'($urandom_range(20, 100));
            write_reg(CSR_ZERO_MIN, 32'(base));
            write_reg(CSR_ZERO_MAX, base + $urandom_range(2, 40));
            base = 16'(board.win.zero_max + $urandom_range(0, 50));
            write_reg(CSR_ONE_MIN, 32'(base));
            write_reg(CSR_ONE_MAX, base + $urandom_range(2, 40));
            write_reg(CSR_LED_LOW_CODE, $urandom);
            write_reg(CSR_LED_HIGH_CODE, $urandom);
         end
         2: begin
            // Extremes: leader window empty, zero window covers every interval but 0 and 65535,
            // one window fully shadowed; all-zero code drives the LED low.
            write_windows(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
            write_reg(CSR_LED_LOW_CODE, 32'h0000_0000);
         end
         3: begin
            // Overlaps: leader beats zero, zero beats one.
            write_windows(16'd400, 16'd600, 16'd50, 16'd550, 16'd300, 16'd700);
            write_reg(CSR_LED_LOW_CODE, $urandom);
            write_reg(CSR_LED_HIGH_CODE, 32'hFFFF_FFFF);
         end
         4: begin
            // Same code in both LED registers: low must win.
            write_windows(RST_LEADER_MIN, RST_LEADER_MAX, RST_ZERO_MIN, RST_ZERO_MAX,
                          RST_ONE_MIN, RST_ONE_MAX);
            shared = $urandom;
            write_reg(CSR_LED_LOW_CODE, shared);
            write_reg(CSR_LED_HIGH_CODE, shared);
         end
         5: begin
            // Raw random settings, windows may be empty or odd.
            write_windows(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            write_reg(CSR_LED_LOW_CODE, $urandom);
            write_reg(CSR_LED_HIGH_CODE, $urandom);
         end
         6: begin
            // Reset values back, sender without gaps.
            write_windows(RST_LEADER_MIN, RST_LEADER_MAX, RST_ZERO_MIN, RST_ZERO_MAX,
                          RST_ONE_MIN, RST_ONE_MAX);
            write_reg(CSR_LED_LOW_CODE, RST_LED_LOW_CODE);
            write_reg(CSR_LED_HIGH_CODE, RST_LED_HIGH_CODE);
            gap_max = 0;
         end
         default: ;
      endcase
   endtask

   // Mostly well-formed frames carrying an LED code, an extreme or a random
   // code; the rest is noise with random intervals or raw capture values.
   task automatic run_traffic();
      int          start;
      logic [31:0] code;
      start = board.captures_taken;
      while (board.captures_taken - start < ITEMS_PER_PHASE) begin
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) == 0)
                  send_capture(16'($urandom_range(0, 65535)));
               else
                  send_interval(16'($urandom_range(0, 65535)));
            end
         end else begin
            case ($urandom_range(0, 5))
               0: code = board.low_code;
               1: code = board.high_code;
               2: code = 32'h0000_0000;
               3: code = 32'hFFFF_FFFF;
               default: code = $urandom;
            endcase
            send_frame(code);
         end
      end
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: first interval measured from zero, every window edge,
      // extreme capture values, a zero interval and a wrap across 2^16.
      send_capture(16'd505);
      foreach (BOUNDARY_GAPS[i]) send_interval(BOUNDARY_GAPS[i]);
      send_capture(16'hFFFF);
      send_capture(16'h0000);
      send_interval(16'd0);
      send_capture(16'hFFC0);
      send_capture(16'h0030);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase != 0) begin
            drain();
            configure_phase(phase);
         end
         run_traffic();
      end

      drain();
      repeat (8) @(posedge clock);
      if (board.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
